@@ sv/pls_pkg.sv @@
// shared types and constants for the positional list store
// used by pls_cell, positional_list_store_unit and pls_checker
package pls_pkg;

  localparam int WORD_W        = 64;
  localparam int POS_W         = 8;
  localparam int COUNT_W       = 5;
  localparam int DEPTH_DEFAULT = 16;
  localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

  // request command codes
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // per-cycle move applied to the whole row of cells
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } shift_op_t;

  // control broadcast to every cell
  typedef struct packed {
    shift_op_t         op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } ctrl_t;

endpackage

@@ sv/pls_cell.sv @@
// one storage cell of the list row: holds one word, shifts with its neighbors
// depends on pls_pkg
module pls_cell import pls_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  ctrl_t             ctrl,
  input  logic [WORD_W-1:0] left,
  input  logic [WORD_W-1:0] right,
  output logic [WORD_W-1:0] value,
  output logic [WORD_W-1:0] tap
);

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic [WORD_W-1:0] value_next;

  // select the new content by this cell's place relative to the position
  always_comb begin
    value_next = value;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (IDX > ctrl.pos) begin
          value_next = left;
        end else if (IDX == ctrl.pos) begin
          value_next = ctrl.word;
        end
      end
      OP_DELETE: begin
        if (IDX >= ctrl.pos) begin
          value_next = right;
        end
      end
      default: value_next = value;
    endcase
  end

  // word storage, no reset
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // read tap, zero unless this cell is addressed
  assign tap = (IDX == ctrl.pos) ? value : '0;

endmodule

@@ sv/positional_list_store_unit.sv @@
// positional list store top level: command decode, fill count, row of cells
// depends on pls_pkg and pls_cell
//
// An ordered list of 64-bit words kept in a row of DEPTH cells. Every cell
// shifts with its neighbors in the same clock, so insert and delete act at
// any position and a new request is taken every cycle unless stalled; the
// result is registered the cycle after the request is accepted. cmd_stall
// rises only while a result sits unread under res_stall. The store contents
// are not cleared by reset; only the fill count, the capacity register and
// res_valid are, so the block takes requests right after reset. The capacity
// limit in force is the smaller of the capacity register and DEPTH.
module positional_list_store_unit import pls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [1:0]         command,
  input  logic [POS_W-1:0]   position,
  input  logic [WORD_W-1:0]  word_in,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               ok,
  output logic [WORD_W-1:0]  word_out,
  output logic [COUNT_W-1:0] count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] capacity_limit
);

  localparam logic [POS_W-1:0] LIM_MAX = POS_W'(DEPTH);

  logic [COUNT_W-1:0] cap_limit;
  logic [COUNT_W-1:0] fill;
  logic [COUNT_W-1:0] fill_next;
  logic [POS_W-1:0]   fill_wide;
  logic [POS_W-1:0]   cap_wide;
  logic [POS_W-1:0]   lim;
  logic               accept;
  logic               ok_next;
  logic [WORD_W-1:0]  word_next;
  logic [WORD_W-1:0]  read_word;
  ctrl_t              ctrl;

  logic [WORD_W-1:0] cell_value [DEPTH];
  logic [WORD_W-1:0] cell_tap   [DEPTH];

  assign cfg_ready = 1'b1;
  assign cmd_stall = res_valid & res_stall;
  assign accept    = cmd_valid & ~cmd_stall;

  // limit in force
  assign fill_wide = {{(POS_W-COUNT_W){1'b0}}, fill};
  assign cap_wide  = {{(POS_W-COUNT_W){1'b0}}, cap_limit};
  assign lim       = (cap_wide > LIM_MAX) ? LIM_MAX : cap_wide;

  // read port: or of the addressed cell's tap
  always_comb begin
    read_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_word = read_word | cell_tap[i];
    end
  end

  // command decode
  always_comb begin
    ok_next   = 1'b0;
    word_next = '0;
    fill_next = fill;
    ctrl.op   = OP_HOLD;
    ctrl.pos  = position;
    ctrl.word = word_in;
    unique case (cmd_t'(command))
      CMD_INSERT: begin
        if (fill_wide < lim) begin
          ok_next   = 1'b1;
          ctrl.op   = accept ? OP_INSERT : OP_HOLD;
          ctrl.pos  = (position > fill_wide) ? fill_wide : position;
          fill_next = fill + 5'd1;
        end
      end
      CMD_GET: begin
        if (position < fill_wide) begin
          ok_next   = 1'b1;
          word_next = read_word;
        end
      end
      CMD_DELETE: begin
        if (position < fill_wide) begin
          ok_next   = 1'b1;
          word_next = read_word;
          ctrl.op   = accept ? OP_DELETE : OP_HOLD;
          fill_next = fill - 5'd1;
        end
      end
      CMD_CLEAR: begin
        ok_next   = 1'b1;
        fill_next = '0;
      end
      default: ok_next = 1'b0;
    endcase
  end

  // row of cells
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] left_in;
      logic [WORD_W-1:0] right_in;
      if (g == 0) begin : g_first
        assign left_in = word_in;
      end else begin : g_mid_l
        assign left_in = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_in = cell_value[g];
      end else begin : g_mid_r
        assign right_in = cell_value[g+1];
      end
      pls_cell #(.INDEX(g)) u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .left  (left_in),
        .right (right_in),
        .value (cell_value[g]),
        .tap   (cell_tap[g])
      );
    end
  endgenerate

  // control state: fill count, capacity register, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cap_limit <= CAP_RESET;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_limit <= capacity_limit;
      end
      if (accept) begin
        fill      <= fill_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ok       <= ok_next;
      word_out <= word_next;
      count    <= fill_next;
    end
  end

endmodule

@@ sv/pls_checker.sv @@
// port-level checks for positional_list_store_unit, bound to the top level
// depends on pls_pkg
module pls_port_assertions import pls_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic               ok,
  input logic [WORD_W-1:0]  word_out,
  input logic [COUNT_W-1:0] count
);

  // every accepted request yields a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> res_valid)
    else $error("accepted request produced no result");

  // requests are held off only while a result waits
  assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (res_valid && res_stall))
    else $error("request stalled without a waiting result");

  // a failed request returns a zero word
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !ok) |-> (word_out == '0))
    else $error("failed request returned a nonzero word");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=>
      (res_valid && $stable(ok) && $stable(word_out) && $stable(count)))
    else $error("stalled result changed");

endmodule

bind positional_list_store_unit pls_port_assertions u_pls_port_assertions (.*);

@@ dv/pls_checker.sv @@
// checker for the positional list store: watches the request, result and config channels
// keeps its own copy of the list, predicts each result and compares; depends on pls_pkg
`timescale 1ns / 1ps

module pls_checker import pls_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  logic [1:0]         command,
  input  logic [POS_W-1:0]   position,
  input  logic [WORD_W-1:0]  word_in,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic               ok,
  input  logic [WORD_W-1:0]  word_out,
  input  logic [COUNT_W-1:0] count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [COUNT_W-1:0] capacity_limit,
  output int                 pending,
  output int                 errors
);

  localparam int DEPTH = DEPTH_DEFAULT;

  typedef struct packed {
    logic               ok;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  // shadow copy of the list and its limit
  logic [WORD_W-1:0]  shadow_list [DEPTH];
  int                 shadow_fill;
  logic [COUNT_W-1:0] shadow_cap;
  list_result_t       awaited_results [$];

  // apply one request to the shadow list and return the result it gives
  function automatic list_result_t apply_request(cmd_t c, logic [POS_W-1:0] p,
                                                 logic [WORD_W-1:0] w);
    list_result_t r;
    int at;
    int lim;
    r = '0;
    lim = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    case (c)
      CMD_INSERT: begin
        if (shadow_fill + 1 <= lim && shadow_fill < DEPTH) begin
          // past the end appends
          at = (int'(p) > shadow_fill) ? shadow_fill : int'(p);
          for (int i = shadow_fill; i > at; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[at] = w;
          shadow_fill++;
          r.ok = 1'b1;
        end
      end
      CMD_GET, CMD_DELETE: begin
        if (int'(p) < shadow_fill) begin
          r.word = shadow_list[p];
          r.ok = 1'b1;
          if (c == CMD_DELETE) begin
            for (int i = int'(p) + 1; i < shadow_fill; i++) shadow_list[i-1] = shadow_list[i];
            shadow_fill--;
          end
        end
      end
      default: begin
        shadow_fill = 0;
        r.ok = 1'b1;
      end
    endcase
    r.count = shadow_fill[COUNT_W-1:0];
    return r;
  endfunction

  // results are checked before the new request of the same edge is predicted
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      awaited_results.delete();
      shadow_fill = 0;
      shadow_cap = CAP_RESET;
      errors = 0;
      pending <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ok=%0b word_out=%h count=%0d",
                   $time, ok, word_out, count);
        end else begin
          want = awaited_results.pop_front();
          if (ok !== want.ok) begin
            errors++;
            $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, ok);
          end
          if (word_out !== want.word) begin
            errors++;
            $display("%0t: word_out mismatch, expected %h, got %h",
                     $time, want.word, word_out);
          end
          if (count !== want.count) begin
            errors++;
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, want.count, count);
          end
        end
      end
      if (cfg_valid && cfg_ready) shadow_cap = capacity_limit;
      if (cmd_valid && !cmd_stall)
        awaited_results.push_back(apply_request(cmd_t'(command), position, word_in));
      pending <= awaited_results.size();
    end
  end

endmodule

@@ dv/tb.sv @@
// testbench top for positional_list_store_unit: clock, reset, request stimulus, verdict
// depends on pls_pkg, positional_list_store_unit and pls_checker
`timescale 1ns / 1ps

module tb;
  import pls_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic               clk;
  logic               rst;
  logic               cmd_valid;
  logic               cmd_stall;
  logic [1:0]         command;
  logic [POS_W-1:0]   position;
  logic [WORD_W-1:0]  word_in;
  logic               res_valid;
  logic               res_stall;
  logic               ok;
  logic [WORD_W-1:0]  word_out;
  logic [COUNT_W-1:0] count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [COUNT_W-1:0] capacity_limit;
  int                 pending;
  int                 errors;
  int                 cycles;

  positional_list_store_unit uut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .position(position), .word_in(word_in),
    .res_valid(res_valid), .res_stall(res_stall),
    .ok(ok), .word_out(word_out), .count(count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity_limit(capacity_limit)
  );

  pls_checker chk (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .position(position), .word_in(word_in),
    .res_valid(res_valid), .res_stall(res_stall),
    .ok(ok), .word_out(word_out), .count(count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .capacity_limit(capacity_limit),
    .pending(pending), .errors(errors)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // cycle count, timeout and result-side stall pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      case ((cycles / 256) % 4)
        0:       res_stall <= 1'b0;
        1:       res_stall <= ($urandom_range(0, 3) == 0);
        2:       res_stall <= ($urandom_range(0, 9) < 7);
        default: res_stall <= (cycles % 3 == 0);
      endcase
    end
  end

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // present one request and hold it until taken
  task automatic send_request(cmd_t c, logic [POS_W-1:0] p, logic [WORD_W-1:0] w);
    cmd_valid <= 1'b1;
    command <= c;
    position <= p;
    word_in <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic pause_requests(int n);
    cmd_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every predicted result has come back
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // change the capacity limit with the block idle
  task automatic set_capacity(logic [COUNT_W-1:0] v);
    drain();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    capacity_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random requests in bursts; ins_pct and del_pct bias the list fill
  task automatic random_requests(int n, int ins_pct, int del_pct, bit gaps);
    int left;
    int burst;
    int r;
    cmd_t c;
    logic [POS_W-1:0] p;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        r = $urandom_range(0, 99);
        if (r < ins_pct) c = CMD_INSERT;
        else if (r < ins_pct + del_pct) c = CMD_DELETE;
        else if (r < 97) c = CMD_GET;
        else c = CMD_CLEAR;
        p = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, 17))
                                        : POS_W'($urandom_range(0, 255));
        send_request(c, p, pick_word());
        burst--;
        left--;
      end
      if ($urandom_range(0, 39) == 0) drain();
      else if (gaps && $urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 6));
    end
  endtask

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    command = CMD_GET;
    position = '0;
    word_in = '0;
    cfg_valid = 1'b0;
    capacity_limit = CAP_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list, clamped append, zero word, out of range reads
    set_capacity(5'd16);
    send_request(CMD_CLEAR, 8'd0, '0);
    send_request(CMD_GET, 8'd0, '0);
    send_request(CMD_DELETE, 8'd0, '0);
    send_request(CMD_INSERT, 8'd255, '1);
    send_request(CMD_INSERT, 8'd0, '0);
    send_request(CMD_INSERT, 8'd1, 64'hA5A5_5A5A_F00F_0FF0);
    send_request(CMD_GET, 8'd0, '1);
    send_request(CMD_GET, 8'd2, '0);
    send_request(CMD_GET, 8'd255, '0);
    send_request(CMD_DELETE, 8'd1, '0);
    send_request(CMD_INSERT, 8'd2, pick_word());
    send_request(CMD_INSERT, 8'd0, pick_word());

    // list full at the limit
    set_capacity(5'd4);
    send_request(CMD_INSERT, 8'd1, pick_word());

    // limit lowered below the fill: entries kept, inserts refused until the fill drops below it
    set_capacity(5'd2);
    send_request(CMD_GET, 8'd3, '0);
    send_request(CMD_DELETE, 8'd3, '0);
    send_request(CMD_INSERT, 8'd0, pick_word());
    send_request(CMD_DELETE, 8'd0, '0);
    send_request(CMD_INSERT, 8'd0, pick_word());
    send_request(CMD_DELETE, 8'd0, '0);
    send_request(CMD_DELETE, 8'd0, '0);
    send_request(CMD_INSERT, 8'd7, pick_word());

    // zero capacity
    set_capacity(5'd0);
    send_request(CMD_INSERT, 8'd0, pick_word());
    send_request(CMD_CLEAR, 8'd0, '0);
    send_request(CMD_INSERT, 8'd0, pick_word());

    // random phases over several limits, above the store depth too
    set_capacity(5'd16);
    random_requests(130, 60, 15, 1'b1);
    set_capacity(5'd31);
    random_requests(130, 55, 20, 1'b0);
    set_capacity(5'd3);
    random_requests(120, 45, 25, 1'b1);
    set_capacity(5'd17);
    random_requests(130, 35, 40, 1'b1);
    set_capacity(5'd0);
    random_requests(60, 40, 30, 1'b1);
    set_capacity(5'd1);
    random_requests(100, 45, 25, 1'b0);
    set_capacity(5'd9);
    random_requests(130, 55, 20, 1'b1);
    set_capacity(COUNT_W'($urandom_range(0, 31)));
    random_requests(100, 50, 25, 1'b1);
    set_capacity(5'd16);
    random_requests(100, 65, 10, 1'b1);

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
